// ----- src/modexp_pkg.sv -----
// Package: widths, reset values and register indexes for the modular exponentiation block.
package modexp_pkg;
    localparam int MOD_WIDTH_DEF = 32;
    localparam int REG_WIDTH     = 32;
    localparam int KEY_P         = 55639;
    localparam int KEY_Q         = 68767;
    localparam logic [REG_WIDTH-1:0] EXP_RESET = 32'd7;
    localparam logic [63:0] MOD_RESET_64 = 64'(KEY_P) * 64'(KEY_Q);
    localparam logic [REG_WIDTH-1:0] MOD_RESET = MOD_RESET_64[REG_WIDTH-1:0];
    localparam logic CFG_IDX_EXPONENT = 1'b0;
    localparam logic CFG_IDX_MODULUS  = 1'b1;
endpackage

// ----- src/modexp_cell.sv -----
// Cell: one modular double-and-add step of an interleaved serial multiplier.
module modexp_cell #(
    parameter int W = modexp_pkg::MOD_WIDTH_DEF
) (
    input  logic [W-1:0] i_r,
    input  logic         i_bit,
    input  logic [W-1:0] i_x,
    input  logic [W-1:0] i_m,
    output logic [W-1:0] o_r
);
    logic [W:0] s1;
    logic [W:0] d1;
    logic [W-1:0] r1;
    logic [W:0] s2;
    logic [W:0] d2;

    always_comb begin
        s1 = {1'b0, i_r} + {1'b0, i_r};
        d1 = s1 - {1'b0, i_m};
        r1 = d1[W] ? s1[W-1:0] : d1[W-1:0];
        s2 = {1'b0, r1} + (i_bit ? {1'b0, i_x} : '0);
        d2 = s2 - {1'b0, i_m};
        o_r = (i_bit && !d2[W]) ? d2[W-1:0] : (i_bit ? s2[W-1:0] : r1);
    end
endmodule

// ----- src/modexp_mul.sv -----
// Modular multiplier: a short row of cells, one cell per multiplier bit, applied each cycle while busy.
module modexp_mul #(
    parameter int W     = modexp_pkg::MOD_WIDTH_DEF,
    parameter int CELLS = 2
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic [W-1:0] i_x,
    input  logic [W-1:0] i_y,
    input  logic [W-1:0] i_m,
    output logic     o_done,
    output logic [W-1:0] o_p
);
    localparam int STEPS = (W + CELLS - 1) / CELLS;
    localparam int CW    = $clog2(STEPS + 1);
    localparam int YW    = STEPS * CELLS;

    logic [W-1:0]  r_acc;
    logic [YW-1:0] r_y;
    logic [W-1:0]  r_x;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [W-1:0]  w_r [CELLS+1];

    assign w_r[0] = r_acc;
    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        modexp_cell #(.W(W)) u_cell (
            .i_r(w_r[g]), .i_bit(r_y[YW-1-g]), .i_x(r_x), .i_m(i_m), .o_r(w_r[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_x   <= i_x;
            r_y   <= YW'(i_y) << (YW - W);
        end else if (r_busy) begin
            r_acc <= w_r[CELLS];
            r_y   <= r_y << CELLS;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;
endmodule

// ----- src/modular_exponentiation_top.sv -----
// Top level: streaming modular exponentiation by square-and-multiply.
// One request in, one result out. The message is reduced modulo the modulus
// register, then raised to the exponent register by scanning the exponent
// from its top bit: square every step, multiply when the bit is set. Each
// modular product runs through a shared serial multiplier made of a row of
// two double-and-add cells. The initial reduction is one product (message
// times 1, with the message first brought below 2^MOD_WIDTH and reduced by
// the same row). Leading zero exponent bits are skipped with no product.
// With E = min(MOD_WIDTH, 32) exponent bits the worst case (all bits set) is
// 2*E products plus a bookkeeping step per exponent bit; the multiplier is
// the limit. Modulus 0 or 1 gives 0, exponent 0 gives 1 mod modulus. tlast
// rides along unchanged. The result sits in an output register; a new
// request is taken once it is gone.
module modular_exponentiation_top #(
    parameter int MOD_WIDTH = modexp_pkg::MOD_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] message
    input  logic        s_axis_tlast,   // final_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] cipher
    output logic        m_axis_tlast    // final_result
);
    localparam int W  = MOD_WIDTH;
    localparam int EW = (W < 32) ? W : 32;
    localparam int IW = $clog2(EW + 1);
    localparam int BW = $clog2(W);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RED  = 3'd1;
    localparam logic [2:0] ST_SQR  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;
    localparam logic [2:0] ST_WRED = 3'd5;

    logic [31:0] r_exp;
    logic [31:0] r_mod;
    logic [2:0]  r_st;
    logic [W-1:0] r_base;
    logic [W-1:0] r_res;
    logic [IW-1:0] r_idx;
    logic        r_lead;
    logic        r_last;
    logic        r_ovalid;
    logic [31:0] r_odata;
    logic        r_olast;
    logic        r_wait;

    logic [W-1:0] w_m;
    logic [W-1:0] w_e;
    logic [W-1:0] w_msg;
    logic [W-1:0] w_one;
    logic         w_start;
    logic         w_done;
    logic [W-1:0] w_p;
    logic [W-1:0] w_x;
    logic [W-1:0] w_y;
    logic         w_bit;
    logic         w_trivial;

    always_comb begin
        w_m   = W'({{(W > 32 ? W - 32 : 0){1'b0}}, r_mod});
        w_e   = W'({{(W > 32 ? W - 32 : 0){1'b0}}, r_exp});
        w_msg = W'({{(W > 32 ? W - 32 : 0){1'b0}}, s_axis_tdata});
        w_one = W'(1);
        w_bit = w_e[BW'(r_idx - IW'(1))];
        w_trivial = (w_m == '0) || (w_m == w_one);
    end

    // message times one through the cell row gives message mod m (message < 2^W)
    // but the row needs x < m, so reduction uses y = message, x = 1.
    always_comb begin
        w_x = r_res;
        w_y = r_res;
        case (r_st)
            ST_RED:  begin w_x = w_one; w_y = r_base; end
            ST_SQR:  begin w_x = r_res; w_y = r_res;  end
            ST_MUL:  begin w_x = r_base; w_y = r_res; end
            default: begin w_x = r_res; w_y = r_res;  end
        endcase
    end

    modexp_mul #(.W(W), .CELLS(2)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_x(w_x), .i_y(w_y), .i_m(w_m), .o_done(w_done), .o_p(w_p)
    );

    assign s_axis_tready = (r_st == ST_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= modexp_pkg::EXP_RESET;
            r_mod <= modexp_pkg::MOD_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == modexp_pkg::CFG_IDX_EXPONENT) r_exp <= i_cfg_data;
            else r_mod <= i_cfg_data;
        end
    end

    // start pulse: raised in the cycle a product is launched
    always_comb begin
        w_start = 1'b0;
        if (!r_wait) begin
            case (r_st)
                ST_RED:  w_start = 1'b1;
                ST_SQR:  w_start = !r_lead && (r_idx != '0);
                ST_MUL:  w_start = 1'b1;
                default: w_start = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_wait   <= 1'b0;
            r_lead   <= 1'b1;
            r_idx    <= '0;
        end else begin
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_base <= w_msg;
                        r_last <= s_axis_tlast;
                        r_res  <= w_trivial ? '0 : w_one;
                        r_idx  <= IW'(EW);
                        r_lead <= 1'b1;
                        r_st   <= w_trivial ? ST_OUT : ST_RED;
                    end
                end
                ST_RED: begin
                    if (w_start) r_wait <= 1'b1;
                    else if (w_done) begin
                        r_wait <= 1'b0;
                        r_base <= w_p;
                        r_st   <= ST_SQR;
                    end
                end
                ST_SQR: begin
                    if (w_start) r_wait <= 1'b1;
                    else if (r_wait) begin
                        if (w_done) begin
                            r_wait <= 1'b0;
                            r_res  <= w_p;
                            r_st   <= w_bit ? ST_MUL : ST_WRED;
                        end
                    end else if (r_idx == '0) begin
                        r_st <= ST_OUT;
                    end else if (!w_bit) begin
                        r_idx <= r_idx - IW'(1);   // leading zero: squaring 1 is 1
                    end else begin
                        r_lead <= 1'b0;
                        r_st   <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (w_start) r_wait <= 1'b1;
                    else if (w_done) begin
                        r_wait <= 1'b0;
                        r_res  <= w_p;
                        r_st   <= ST_WRED;
                    end
                end
                ST_WRED: begin
                    r_idx <= r_idx - IW'(1);
                    r_st  <= (r_idx == IW'(1)) ? ST_OUT : ST_SQR;
                end
                ST_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= 32'(r_res);
                        r_olast  <= r_last;
                        r_st     <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != ST_IDLE) |-> !s_axis_tready) else $error("accept while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !m_axis_tready) |=> (r_ovalid && $stable(r_odata)))
        else $error("result dropped");
    a_no_double_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |-> !r_wait) else $error("multiplier restarted");
    a_res_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_OUT && !w_trivial) |-> (r_res < w_m)) else $error("unreduced");
`endif
endmodule

// ----- dv/modexp_checker.sv -----
// Checker: watches both streams, predicts each cipher and compares in order.
module modexp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [31:0] i_req_msg,
    input  logic        i_req_last,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [31:0] i_res_cipher,
    input  logic        i_res_last,
    output int          o_fail_cnt,
    output int          o_pending
);
    typedef struct {
        logic [31:0] cipher;
        logic        last;
    } t_cipher;

    logic [31:0] r_exp;
    logic [31:0] r_mod;
    t_cipher     cipher_q[$];

    // base^e mod m, 64-bit intermediates are enough at 32 bits
    function automatic logic [31:0] pow_mod(logic [31:0] base, logic [31:0] e,
                                            logic [31:0] m);
        logic [63:0] r;
        logic [63:0] b;
        if (m == 0) return '0;
        b = base % m;
        r = 64'd1 % m;
        for (int i = 31; i >= 0; i--) begin
            r = (r * r) % m;
            if (e[i]) r = (r * b) % m;
        end
        return r[31:0];
    endfunction

    always @(posedge i_clk) begin
        t_cipher got;
        t_cipher want;
        int      errs;
        errs = 0;
        if (!i_rst_n) begin
            r_exp      <= modexp_pkg::EXP_RESET;
            r_mod      <= modexp_pkg::MOD_RESET;
            o_fail_cnt <= 0;
            o_pending  <= 0;
            cipher_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == modexp_pkg::CFG_IDX_EXPONENT) r_exp <= i_cfg_data;
                else r_mod <= i_cfg_data;
            end
            if (i_req_valid && i_req_ready) begin
                want.cipher = pow_mod(i_req_msg, r_exp, r_mod);
                want.last   = i_req_last;
                cipher_q.push_back(want);
            end
            if (i_res_valid && i_res_ready) begin
                got.cipher = i_res_cipher;
                got.last   = i_res_last;
                if (cipher_q.size() == 0) begin
                    $error("cipher: expected none actual %h", got.cipher);
                    errs++;
                end else begin
                    want = cipher_q.pop_front();
                    if (got.cipher !== want.cipher) begin
                        $error("cipher: expected %h actual %h", want.cipher, got.cipher);
                        errs++;
                    end
                    if (got.last !== want.last) begin
                        $error("final_result: expected %b actual %b", want.last, got.last);
                        errs++;
                    end
                end
            end
            o_fail_cnt <= o_fail_cnt + errs;
            o_pending  <= cipher_q.size();
        end
    end
endmodule

// ----- dv/modular_exponentiation_top_tb.sv -----
// Testbench top: drives config and requests, random stalls, gives the verdict.
module modular_exponentiation_top_tb;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = modexp_pkg::CFG_IDX_EXPONENT;
    logic [31:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [31:0] message
    logic        s_axis_tlast = 1'b0; // final_word
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [31:0] cipher
    logic        m_axis_tlast;        // final_result
    int          fail_cnt;
    int          pending;
    bit          calm = 1'b0;  // no idling on either side
    bit          hold = 1'b0;  // long receiver hold-off

    always #5 i_clk = ~i_clk;

    modular_exponentiation_top u_top (.*);

    modexp_checker u_chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_req_valid(s_axis_tvalid), .i_req_ready(s_axis_tready),
        .i_req_msg(s_axis_tdata), .i_req_last(s_axis_tlast),
        .i_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .i_res_cipher(m_axis_tdata), .i_res_last(m_axis_tlast),
        .o_fail_cnt(fail_cnt), .o_pending(pending)
    );

    // receiver: random stalls, none while calm, stalled throughout hold
    always @(posedge i_clk) begin
        if (hold) m_axis_tready <= 1'b0;
        else m_axis_tready <= calm || ($urandom_range(99) >= 9);
    end

    // one request, with random idle cycles in front; valid stays up afterwards
    task automatic send_msg(logic [31:0] msg, logic last);
        while (!calm && $urandom_range(99) < 9) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= msg;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // only touch registers once all results are back and the core is idle
    task automatic write_reg(logic idx, logic [31:0] val);
        while (pending != 0) @(posedge i_clk);
        repeat (1300) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_msg(logic [31:0] m);
        case ($urandom_range(3))
            0: return $urandom();
            1: return (m == 0) ? 32'd0 : $urandom() % m;
            2: return m - $urandom_range(1, 0);
            default: return $urandom_range(3);
        endcase
    endfunction

    // key settings: small, extreme and reset
    logic [31:0] exps[8] = '{32'd7, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd65537, 32'd3,
                             32'h8000_0001, 32'd2};
    logic [31:0] mods[8] = '{modexp_pkg::MOD_RESET, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd2,
                             32'hFFFF_FFFB, 32'd97, 32'h8000_0000};

    initial begin
        logic [31:0] cur_mod;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: field extremes under reset key
        send_msg(32'd0, 1'b0);
        send_msg(32'd1, 1'b1);
        send_msg(32'hFFFF_FFFF, 1'b0);
        send_msg(modexp_pkg::MOD_RESET, 1'b1);
        send_msg(modexp_pkg::MOD_RESET - 1, 1'b0);
        send_msg(modexp_pkg::MOD_RESET + 1, 1'b1);
        send_msg(32'h5555_5555, 1'b0);
        send_msg(32'hAAAA_AAAA, 1'b1);
        // backpressure: hold receiver while requests keep coming
        fork
            begin
                hold = 1'b1;
                repeat (4000) @(posedge i_clk);
                hold = 1'b0;
            end
            begin
                repeat (4) send_msg($urandom(), 1'($urandom_range(1)));
                s_axis_tvalid <= 1'b0;
            end
        join
        // random phases across key settings
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(modexp_pkg::CFG_IDX_EXPONENT, exps[ph]);
            write_reg(modexp_pkg::CFG_IDX_MODULUS, mods[(ph + 3) % 8]);
            cur_mod = mods[(ph + 3) % 8];
            calm = (ph == 4);
            for (int n = 0; n < 65; n++) begin
                send_msg(rand_msg(cur_mod), 1'($urandom_range(1)));
            end
            s_axis_tvalid <= 1'b0;
        end
        calm = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (1300) @(posedge i_clk);
        if (fail_cnt == 0) $display("modular_exponentiation_top_tb: done, clean");
        else $display("modular_exponentiation_top_tb: done, errors");
        $finish;
    end

    // watchdog: sized for ~560 requests, stalled, with margin
    initial begin
        #50_000_000;
        $display("modular_exponentiation_top_tb: done, errors");
        $finish;
    end
endmodule
